/* design/can_block_transfer_engine_top_defines.svh */
// ----------------------------------------------------------------------------
// Block transfer engine assertion macros
// Concurrent assertion wrappers that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CAN_BLOCK_TRANSFER_ENGINE_TOP_DEFINES_SVH
`define CAN_BLOCK_TRANSFER_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CBTE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define CBTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CBTE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define CBTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* design/cbte_pkg.sv */
// ----------------------------------------------------------------------------
// Block transfer engine package
// Shared constants, codes and transfer types.
// ----------------------------------------------------------------------------
package cbte_pkg;

    localparam int REQUEST_DEPTH = 4096;
    localparam int ADDR_W = $clog2(REQUEST_DEPTH);
    localparam int CNT_W = $clog2(REQUEST_DEPTH + 1);

    localparam logic [30:0] ID_FIRST = 31'h40000000;
    localparam logic [30:0] ID_LAST = 31'h20000000;
    localparam logic [30:0] ID_REPLY = 31'h10000000;
    localparam logic [30:0] ID_WRITE = 31'h08000000;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_REPLY = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WRITE = 2'd1;
    localparam logic [1:0] PH_READ = 2'd2;

    localparam logic [1:0] CFG_BUS_REQ = 2'd0;
    localparam logic [1:0] CFG_BUS_REP = 2'd1;
    localparam logic [1:0] CFG_CAPACITY = 2'd2;

    localparam logic [4:0] STATUS_OK = 5'd0;
    localparam logic [4:0] STATUS_LINK = 5'd1;
    localparam logic [4:0] STATUS_BAD_TYPE = 5'd2;
    localparam logic [4:0] STATUS_W_NOT_REPLY = 5'd3;
    localparam logic [4:0] STATUS_W_DIR = 5'd4;
    localparam logic [4:0] STATUS_W_ERR = 5'd5;
    localparam logic [4:0] STATUS_W_ABORT = 5'd6;
    localparam logic [4:0] STATUS_W_NOT_NXT = 5'd7;
    localparam logic [4:0] STATUS_W_WRITE = 5'd8;
    localparam logic [4:0] STATUS_W_NOT_FIRST = 5'd9;
    localparam logic [4:0] STATUS_W_OVERFLOW = 5'd10;
    localparam logic [4:0] STATUS_R_NOT_REPLY = 5'd11;
    localparam logic [4:0] STATUS_R_WRITE = 5'd12;
    localparam logic [4:0] STATUS_R_ERR = 5'd13;
    localparam logic [4:0] STATUS_R_ABORT = 5'd14;
    localparam logic [4:0] STATUS_R_NXT = 5'd15;
    localparam logic [4:0] STATUS_R_FIRST = 5'd16;
    localparam logic [4:0] STATUS_R_OVERFLOW = 5'd17;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  block_type;
        logic [8:0]  node_address;
        logic [7:0]  source_node;
        logic [20:0] data_type;
        logic [12:0] data_count;
        logic [7:0]  data_byte;
        logic [30:0] frame_id;
        logic [3:0]  frame_len;
        logic [63:0] frame_data;
        logic [2:0]  link_error;
    } in_t;

    typedef struct packed {
        logic        send_valid;
        logic [30:0] send_id;
        logic [3:0]  send_len;
        logic [63:0] send_data;
        logic [3:0]  deliver_len;
        logic [63:0] deliver_data;
        logic        done_res;
        logic [4:0]  status;
        logic [2:0]  link_code;
        logic [15:0] reply_total;
    } out_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

/* design/cbte_ram.sv */
// ----------------------------------------------------------------------------
// Block transfer engine request buffer
// Simple dual-port RAM with one registered read port.
// ----------------------------------------------------------------------------
module cbte_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/cbte_engine.sv */
// ----------------------------------------------------------------------------
// Block transfer engine sequencer
// Decodes items, checks replies and gathers request bytes from the buffer.
// ----------------------------------------------------------------------------
module cbte_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_wdata,
    input  logic                 in_valid,
    input  cbte_pkg::in_t        in_data,
    output logic                 in_ready,
    input  logic                 slot_free,
    output logic                 res_valid,
    output cbte_pkg::out_t       res_data,
    output cbte_pkg::ram_req_t   ram_req,
    input  logic [7:0]           ram_rdata
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_GATHER = 1'b1;

    logic state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [cbte_pkg::CNT_W-1:0] lp_reg, lp_next;
    logic [cbte_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic [cbte_pkg::CNT_W-1:0] total_reg, total_next;
    logic [30:0] sid_reg, sid_next;
    logic [15:0] rc_reg, rc_next;
    logic bus_req_reg, bus_rep_reg;
    logic [15:0] cap_reg;
    logic [cbte_pkg::ADDR_W-1:0] g_addr_reg, g_addr_next;
    logic [3:0] g_left_reg, g_left_next;
    logic [2:0] g_pos_reg, g_pos_next;
    logic g_pend_reg, g_pend_next;
    cbte_pkg::out_t g_res_reg, g_res_next;

    always_comb begin
        logic accept;
        logic [7:0] wr_byte;
        logic [3:0] hlen;
        logic [3:0] room;
        logic [3:0] take;
        logic [cbte_pkg::CNT_W-1:0] cnt;
        logic [cbte_pkg::CNT_W-1:0] left;
        logic [30:0] id;
        logic [63:0] hdr;
        logic [1:0] fl;
        logic rep, rwr, swr, z;
        logic is_err, is_abo, is_nxt, is_end, is_opening, is_last;
        logic [3:0] len8;
        logic overflow;
        logic [63:0] dd;
        logic [4:0] code;
        logic fin;
        logic do_chunk, do_take;
        logic [3:0] n;

        state_next = state_reg;
        phase_next = phase_reg;
        lp_next = lp_reg;
        rem_next = rem_reg;
        total_next = total_reg;
        sid_next = sid_reg;
        rc_next = rc_reg;
        g_addr_next = g_addr_reg;
        g_left_next = g_left_reg;
        g_pos_next = g_pos_reg;
        g_pend_next = g_pend_reg;
        g_res_next = g_res_reg;
        res_data = '0;
        res_valid = 1'b0;
        ram_req = '0;
        accept = (state_reg == S_IDLE) && slot_free && in_valid;
        wr_byte = in_data.block_type[0] ? 8'h40 : 8'h00;
        hlen = 4'd1;
        hdr = '0;
        cnt = '0;
        room = '0;
        take = '0;
        left = '0;
        id = '0;
        fl = in_data.frame_id[30:29];
        rep = in_data.frame_id[28];
        rwr = in_data.frame_id[27];
        swr = sid_reg[27];
        z = (in_data.frame_len == 4'd0);
        is_err = z && (fl == 2'b01);
        is_abo = z && (fl == 2'b10);
        is_nxt = z && (fl == 2'b00);
        is_end = z && (fl == 2'b11);
        is_opening = !z && fl[1];
        is_last = !z && fl[0];
        len8 = (in_data.frame_len > 4'd8) ? 4'd8 : in_data.frame_len;
        overflow = ({1'b0, rc_reg} + 17'(len8)) > {1'b0, cap_reg};
        dd = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len8) begin
                dd[i*8 +: 8] = in_data.frame_data[i*8 +: 8];
            end
        end
        code = cbte_pkg::STATUS_OK;
        fin = 1'b0;
        do_chunk = 1'b0;
        do_take = 1'b0;
        n = (rem_reg < cbte_pkg::CNT_W'(8)) ? rem_reg[3:0] : 4'd8;

        if (state_reg == S_GATHER) begin
            if (g_pend_reg) begin
                g_res_next.send_data[g_pos_reg*8 +: 8] = ram_rdata;
                g_pos_next = g_pos_reg + 3'd1;
            end
            if (g_left_reg != 4'd0) begin
                ram_req.re = 1'b1;
                ram_req.raddr = g_addr_reg;
                g_addr_next = g_addr_reg + cbte_pkg::ADDR_W'(1);
                g_left_next = g_left_reg - 4'd1;
                g_pend_next = 1'b1;
            end else begin
                g_pend_next = 1'b0;
                if (!g_pend_reg && slot_free) begin
                    res_data = g_res_reg;
                    res_valid = 1'b1;
                    state_next = S_IDLE;
                end
            end
        end else if (accept) begin
            res_data.reply_total = rc_reg;
            case (in_data.operation)
                cbte_pkg::OP_LOAD: begin
                    if (lp_reg < cbte_pkg::CNT_W'(cbte_pkg::REQUEST_DEPTH)) begin
                        ram_req.we = 1'b1;
                        ram_req.waddr = lp_reg[cbte_pkg::ADDR_W-1:0];
                        ram_req.wdata = in_data.data_byte;
                        lp_next = lp_reg + cbte_pkg::CNT_W'(1);
                    end
                    res_valid = 1'b1;
                end
                cbte_pkg::OP_START: begin
                    lp_next = '0;
                    rc_next = '0;
                    res_data.reply_total = '0;
                    phase_next = cbte_pkg::PH_IDLE;
                    if (in_data.data_type[20:16] == 5'h1F) begin
                        hdr = {40'd0, in_data.data_type[7:0], in_data.data_type[15:8],
                               8'h1F | wr_byte};
                        hlen = 4'd3;
                    end else begin
                        hdr = {56'd0, {3'd0, in_data.data_type[4:0]} | wr_byte};
                        hlen = 4'd1;
                    end
                    if (in_data.data_type[20:16] != 5'h1F &&
                        in_data.data_type[20:16] != 5'h00) begin
                        res_data.done_res = 1'b1;
                        res_data.status = cbte_pkg::STATUS_BAD_TYPE;
                        res_valid = 1'b1;
                    end else begin
                        if (32'(in_data.data_count) > 32'(cbte_pkg::REQUEST_DEPTH)) begin
                            cnt = cbte_pkg::CNT_W'(cbte_pkg::REQUEST_DEPTH);
                        end else begin
                            cnt = cbte_pkg::CNT_W'(in_data.data_count);
                        end
                        room = 4'd8 - hlen;
                        take = (cnt < cbte_pkg::CNT_W'(room)) ? cnt[3:0] : room;
                        left = cnt - cbte_pkg::CNT_W'(take);
                        total_next = cnt;
                        rem_next = left;
                        id = cbte_pkg::ID_FIRST;
                        if (left == '0) id = id | cbte_pkg::ID_LAST;
                        if (in_data.block_type[1]) id = id | cbte_pkg::ID_REPLY;
                        if (in_data.block_type[0]) id = id | cbte_pkg::ID_WRITE;
                        id[26] = bus_req_reg;
                        id[25] = bus_rep_reg;
                        id[24] = in_data.node_address[8];
                        id[23:16] = in_data.source_node;
                        id[15:8] = in_data.node_address[7:0];
                        sid_next = id;
                        phase_next = cbte_pkg::PH_WRITE;
                        res_data.send_valid = 1'b1;
                        res_data.send_id = id;
                        res_data.send_len = hlen + take;
                        res_data.send_data = hdr;
                        if (take == 4'd0) begin
                            res_valid = 1'b1;
                        end else begin
                            g_res_next = res_data;
                            g_addr_next = '0;
                            g_left_next = take;
                            g_pos_next = hlen[2:0];
                            g_pend_next = 1'b0;
                            state_next = S_GATHER;
                        end
                    end
                end
                cbte_pkg::OP_REPLY: begin
                    if (phase_reg != cbte_pkg::PH_IDLE) begin
                        if (in_data.link_error != 3'd0) begin
                            fin = 1'b1;
                            code = cbte_pkg::STATUS_LINK;
                        end else if (phase_reg == cbte_pkg::PH_WRITE) begin
                            if (!rep) begin
                                fin = 1'b1; code = cbte_pkg::STATUS_W_NOT_REPLY;
                            end else if (rwr != swr) begin
                                fin = 1'b1; code = cbte_pkg::STATUS_W_DIR;
                            end else if (is_err) begin
                                fin = 1'b1; code = cbte_pkg::STATUS_W_ERR;
                            end else if (is_abo) begin
                                fin = 1'b1; code = cbte_pkg::STATUS_W_ABORT;
                            end else if (rem_reg != '0) begin
                                if (!is_nxt) begin
                                    fin = 1'b1; code = cbte_pkg::STATUS_W_NOT_NXT;
                                end else begin
                                    do_chunk = 1'b1;
                                end
                            end else if (is_end) begin
                                fin = 1'b1;
                            end else if (rwr) begin
                                fin = 1'b1; code = cbte_pkg::STATUS_W_WRITE;
                            end else if (!is_opening) begin
                                fin = 1'b1; code = cbte_pkg::STATUS_W_NOT_FIRST;
                            end else if (overflow) begin
                                fin = 1'b1; code = cbte_pkg::STATUS_W_OVERFLOW;
                            end else begin
                                do_take = 1'b1;
                            end
                        end else begin
                            if (!rep) begin
                                fin = 1'b1; code = cbte_pkg::STATUS_R_NOT_REPLY;
                            end else if (rwr) begin
                                fin = 1'b1; code = cbte_pkg::STATUS_R_WRITE;
                            end else if (is_end) begin
                                fin = 1'b1;
                            end else if (is_err) begin
                                fin = 1'b1; code = cbte_pkg::STATUS_R_ERR;
                            end else if (is_abo) begin
                                fin = 1'b1; code = cbte_pkg::STATUS_R_ABORT;
                            end else if (is_nxt) begin
                                fin = 1'b1; code = cbte_pkg::STATUS_R_NXT;
                            end else if (is_opening) begin
                                fin = 1'b1; code = cbte_pkg::STATUS_R_FIRST;
                            end else if (overflow) begin
                                fin = 1'b1; code = cbte_pkg::STATUS_R_OVERFLOW;
                            end else begin
                                do_take = 1'b1;
                            end
                        end
                    end
                    if (do_take) begin
                        res_data.deliver_len = len8;
                        res_data.deliver_data = dd;
                        rc_next = rc_reg + 16'(len8);
                        res_data.reply_total = rc_reg + 16'(len8);
                        if (is_last) begin
                            fin = 1'b1;
                        end else begin
                            id = sid_reg & ~(cbte_pkg::ID_FIRST | cbte_pkg::ID_LAST);
                            sid_next = id;
                            res_data.send_valid = 1'b1;
                            res_data.send_id = id;
                            phase_next = cbte_pkg::PH_READ;
                        end
                    end
                    if (fin) begin
                        res_data.done_res = 1'b1;
                        res_data.status = code;
                        if (code == cbte_pkg::STATUS_LINK) begin
                            res_data.link_code = in_data.link_error;
                        end
                        phase_next = cbte_pkg::PH_IDLE;
                    end
                    if (do_chunk) begin
                        left = rem_reg - cbte_pkg::CNT_W'(n);
                        rem_next = left;
                        id = sid_reg & ~(cbte_pkg::ID_FIRST | cbte_pkg::ID_LAST);
                        if (left == '0) id = id | cbte_pkg::ID_LAST;
                        sid_next = id;
                        res_data.send_valid = 1'b1;
                        res_data.send_id = id;
                        res_data.send_len = n;
                        g_res_next = res_data;
                        g_addr_next = cbte_pkg::ADDR_W'(total_reg - rem_reg);
                        g_left_next = n;
                        g_pos_next = 3'd0;
                        g_pend_next = 1'b0;
                        state_next = S_GATHER;
                    end else begin
                        res_valid = 1'b1;
                    end
                end
                default: begin
                    res_valid = 1'b1;
                end
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE) && slot_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= cbte_pkg::PH_IDLE;
            lp_reg <= '0;
            rem_reg <= '0;
            total_reg <= '0;
            sid_reg <= '0;
            rc_reg <= '0;
            bus_req_reg <= 1'b0;
            bus_rep_reg <= 1'b0;
            cap_reg <= 16'd4096;
            g_left_reg <= '0;
            g_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            lp_reg <= lp_next;
            rem_reg <= rem_next;
            total_reg <= total_next;
            sid_reg <= sid_next;
            rc_reg <= rc_next;
            g_left_reg <= g_left_next;
            g_pend_reg <= g_pend_next;
            if (cfg_we) begin
                case (cfg_index)
                    cbte_pkg::CFG_BUS_REQ: bus_req_reg <= cfg_wdata[0];
                    cbte_pkg::CFG_BUS_REP: bus_rep_reg <= cfg_wdata[0];
                    cbte_pkg::CFG_CAPACITY: cap_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        g_addr_reg <= g_addr_next;
        g_pos_reg <= g_pos_next;
        g_res_reg <= g_res_next;
    end

endmodule

/* design/can_block_transfer_engine_top.sv */
// ----------------------------------------------------------------------------
// Block transfer engine top level
// Request buffer, reply checking sequencer and result register.
// ----------------------------------------------------------------------------
//  Channel   Ports                           Moves
//  input     s_valid s_ready s_data          one item per transfer
//  result    m_valid m_ready m_data          one result per accepted item
//  config    cfg_we cfg_index cfg_wdata      one register write per cycle
//
// Load and no-op items, and replies that gather no buffer bytes, finish in the
// accepting cycle and may follow back to back while the result slot is free.
// A frame with n buffered payload bytes passes the accepting cycle, n reads
// from the single buffer read port, taking the last byte and a result load.
// Reset is synchronous and active low; the buffer itself is not cleared.
// A stalled result holds the next item at the input until the register drains.
// ----------------------------------------------------------------------------
`include "can_block_transfer_engine_top_defines.svh"

module can_block_transfer_engine_top (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  cbte_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output cbte_pkg::out_t  m_data
);

    cbte_pkg::ram_req_t ram_req;
    logic [7:0] ram_rdata;
    logic res_valid;
    cbte_pkg::out_t res_data;
    logic slot_free;
    logic m_valid_reg;
    cbte_pkg::out_t m_data_reg;

    assign slot_free = !m_valid_reg || m_ready;

    cbte_ram #(
        .DEPTH(cbte_pkg::REQUEST_DEPTH),
        .WIDTH(8)
    ) u_ram (
        .aclk(aclk),
        .we(ram_req.we),
        .waddr(ram_req.waddr),
        .wdata(ram_req.wdata),
        .re(ram_req.re),
        .raddr(ram_req.raddr),
        .rdata(ram_rdata)
    );

    cbte_engine u_engine (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_valid(s_valid),
        .in_data(s_data),
        .in_ready(s_ready),
        .slot_free(slot_free),
        .res_valid(res_valid),
        .res_data(res_data),
        .ram_req(ram_req),
        .ram_rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    `CBTE_ASSERT_IMPL(a_done_no_send, aclk, aresetn, m_valid && m_data.done_res, !m_data.send_valid, "finished transfer also sends a frame")
    `CBTE_ASSERT_IMPL(a_status_done, aclk, aresetn, m_valid && m_data.status != 5'd0, m_data.done_res, "nonzero status without finish")
    `CBTE_ASSERT_IMPL(a_deliver_next, aclk, aresetn, m_valid && m_data.deliver_len != 4'd0, m_data.send_valid || m_data.done_res, "delivery without poll or finish")
    `CBTE_ASSERT_IMPL(a_send_len, aclk, aresetn, m_valid, m_data.send_len <= 4'd8, "frame longer than eight bytes")

endmodule

/* bench/cbte_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block transfer engine checker
// Watches the configuration port and both channels, predicts the result of
// every accepted input transfer and compares each result transfer against
// the oldest prediction.
// ----------------------------------------------------------------------------
module cbte_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_wdata,
    input  logic           s_valid,
    input  logic           s_ready,
    input  cbte_pkg::in_t  s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  cbte_pkg::out_t m_data,
    output int             errors,
    output int             pending,
    output int             checked
);

    logic        bus_req;
    logic        bus_rep;
    logic [15:0] capacity;

    logic [1:0]  eng_phase;
    logic [7:0]  request_mem [cbte_pkg::REQUEST_DEPTH];
    int          load_ptr;
    int          remaining;
    int          total_len;
    logic [30:0] sent_id;
    int          reply_cnt;

    cbte_pkg::out_t pending_results [$];

    function automatic logic [63:0] gather_bytes(input int first, input int n,
                                                 input int shift);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n && shift + i < 8; i++) begin
            if (first + i < cbte_pkg::REQUEST_DEPTH) begin
                v |= 64'(request_mem[first + i]) << (8 * (shift + i));
            end
        end
        return v;
    endfunction

    function automatic void finish_transfer(inout cbte_pkg::out_t r,
                                            input logic [4:0] st,
                                            input logic [2:0] lc);
        r.done_res = 1'b1;
        r.status = st;
        r.link_code = lc;
        eng_phase = cbte_pkg::PH_IDLE;
    endfunction

    function automatic void send_next_chunk(inout cbte_pkg::out_t r);
        int          n;
        logic [30:0] id;
        n = remaining < 8 ? remaining : 8;
        id = sent_id & ~(cbte_pkg::ID_FIRST | cbte_pkg::ID_LAST);
        r.send_data = gather_bytes(total_len - remaining, n, 0);
        remaining -= n;
        if (remaining == 0) begin
            id |= cbte_pkg::ID_LAST;
        end
        sent_id = id;
        r.send_valid = 1'b1;
        r.send_id = id;
        r.send_len = 4'(n);
    endfunction

    function automatic void send_nxt_poll(inout cbte_pkg::out_t r);
        sent_id &= ~(cbte_pkg::ID_FIRST | cbte_pkg::ID_LAST);
        r.send_valid = 1'b1;
        r.send_id = sent_id;
    endfunction

    function automatic bit deliver_reply(inout cbte_pkg::out_t r, input int len,
                                         input logic [63:0] fd);
        if (reply_cnt + len > int'(capacity)) begin
            return 1'b0;
        end
        r.deliver_len = 4'(len);
        r.deliver_data = (len >= 8) ? fd : (fd & ((64'd1 << (8 * len)) - 64'd1));
        reply_cnt += len;
        return 1'b1;
    endfunction

    function automatic void start_transfer(input cbte_pkg::in_t it,
                                           inout cbte_pkg::out_t r);
        logic [7:0]  wr;
        logic [63:0] hdr;
        logic [30:0] id;
        int          hlen;
        int          cnt;
        int          take;
        wr = it.block_type[0] ? 8'h40 : 8'h00;
        load_ptr = 0;
        reply_cnt = 0;
        eng_phase = cbte_pkg::PH_IDLE;
        if (it.data_type[20:16] == 5'h1F) begin
            hdr = 64'(8'h1F | wr) | (64'(it.data_type[15:8]) << 8) |
                  (64'(it.data_type[7:0]) << 16);
            hlen = 3;
        end else if (it.data_type[20:16] == 5'h00) begin
            hdr = 64'({3'b000, it.data_type[4:0]} | wr);
            hlen = 1;
        end else begin
            finish_transfer(r, cbte_pkg::STATUS_BAD_TYPE, 3'd0);
            return;
        end
        cnt = int'(it.data_count);
        if (cnt > cbte_pkg::REQUEST_DEPTH) begin
            cnt = cbte_pkg::REQUEST_DEPTH;
        end
        total_len = cnt;
        take = cnt < 8 - hlen ? cnt : 8 - hlen;
        hdr |= gather_bytes(0, take, hlen);
        remaining = cnt - take;
        id = cbte_pkg::ID_FIRST;
        if (remaining == 0) begin
            id |= cbte_pkg::ID_LAST;
        end
        if (it.block_type[1]) begin
            id |= cbte_pkg::ID_REPLY;
        end
        if (it.block_type[0]) begin
            id |= cbte_pkg::ID_WRITE;
        end
        id[26] = bus_req;
        id[25] = bus_rep;
        id[24] = it.node_address[8];
        id[23:16] = it.source_node;
        id[15:8] = it.node_address[7:0];
        sent_id = id;
        r.send_valid = 1'b1;
        r.send_id = id;
        r.send_len = 4'(hlen + take);
        r.send_data = hdr;
        eng_phase = cbte_pkg::PH_WRITE;
    endfunction

    function automatic void check_reply(input cbte_pkg::in_t it,
                                        inout cbte_pkg::out_t r);
        logic [30:0] rid;
        logic [30:0] fl;
        int          len;
        bit          rep, rwr, swr, z;
        bit          is_err, is_abo, is_nxt, is_end, is_opening, is_last;
        rid = it.frame_id;
        len = int'(it.frame_len);
        fl = rid & (cbte_pkg::ID_FIRST | cbte_pkg::ID_LAST);
        rep = (rid & cbte_pkg::ID_REPLY) != 0;
        rwr = (rid & cbte_pkg::ID_WRITE) != 0;
        swr = (sent_id & cbte_pkg::ID_WRITE) != 0;
        z = len == 0;
        is_err = z && fl == cbte_pkg::ID_LAST;
        is_abo = z && fl == cbte_pkg::ID_FIRST;
        is_nxt = z && fl == 0;
        is_end = z && fl == (cbte_pkg::ID_FIRST | cbte_pkg::ID_LAST);
        is_opening = !z && (rid & cbte_pkg::ID_FIRST) != 0;
        is_last = !z && (rid & cbte_pkg::ID_LAST) != 0;
        if (len > 8) begin
            len = 8;
        end
        if (eng_phase == cbte_pkg::PH_IDLE) begin
            return;
        end
        if (it.link_error != 3'd0) begin
            finish_transfer(r, cbte_pkg::STATUS_LINK, it.link_error);
            return;
        end
        if (eng_phase == cbte_pkg::PH_WRITE) begin
            if (!rep) begin
                finish_transfer(r, cbte_pkg::STATUS_W_NOT_REPLY, 3'd0);
            end else if (rwr != swr) begin
                finish_transfer(r, cbte_pkg::STATUS_W_DIR, 3'd0);
            end else if (is_err) begin
                finish_transfer(r, cbte_pkg::STATUS_W_ERR, 3'd0);
            end else if (is_abo) begin
                finish_transfer(r, cbte_pkg::STATUS_W_ABORT, 3'd0);
            end else if (remaining != 0) begin
                if (!is_nxt) begin
                    finish_transfer(r, cbte_pkg::STATUS_W_NOT_NXT, 3'd0);
                end else begin
                    send_next_chunk(r);
                end
            end else if (is_end) begin
                finish_transfer(r, cbte_pkg::STATUS_OK, 3'd0);
            end else if (rwr) begin
                finish_transfer(r, cbte_pkg::STATUS_W_WRITE, 3'd0);
            end else if (!is_opening) begin
                finish_transfer(r, cbte_pkg::STATUS_W_NOT_FIRST, 3'd0);
            end else if (!deliver_reply(r, len, it.frame_data)) begin
                finish_transfer(r, cbte_pkg::STATUS_W_OVERFLOW, 3'd0);
            end else if (is_last) begin
                finish_transfer(r, cbte_pkg::STATUS_OK, 3'd0);
            end else begin
                send_nxt_poll(r);
                eng_phase = cbte_pkg::PH_READ;
            end
            return;
        end
        if (!rep) begin
            finish_transfer(r, cbte_pkg::STATUS_R_NOT_REPLY, 3'd0);
        end else if (rwr) begin
            finish_transfer(r, cbte_pkg::STATUS_R_WRITE, 3'd0);
        end else if (is_end) begin
            finish_transfer(r, cbte_pkg::STATUS_OK, 3'd0);
        end else if (is_err) begin
            finish_transfer(r, cbte_pkg::STATUS_R_ERR, 3'd0);
        end else if (is_abo) begin
            finish_transfer(r, cbte_pkg::STATUS_R_ABORT, 3'd0);
        end else if (is_nxt) begin
            finish_transfer(r, cbte_pkg::STATUS_R_NXT, 3'd0);
        end else if (is_opening) begin
            finish_transfer(r, cbte_pkg::STATUS_R_FIRST, 3'd0);
        end else if (!deliver_reply(r, len, it.frame_data)) begin
            finish_transfer(r, cbte_pkg::STATUS_R_OVERFLOW, 3'd0);
        end else if (is_last) begin
            finish_transfer(r, cbte_pkg::STATUS_OK, 3'd0);
        end else begin
            send_nxt_poll(r);
        end
    endfunction

    function automatic cbte_pkg::out_t engine_step(input cbte_pkg::in_t it);
        cbte_pkg::out_t r;
        r = '0;
        case (it.operation)
            cbte_pkg::OP_LOAD: begin
                if (load_ptr < cbte_pkg::REQUEST_DEPTH) begin
                    request_mem[load_ptr] = it.data_byte;
                    load_ptr++;
                end
            end
            cbte_pkg::OP_START: start_transfer(it, r);
            cbte_pkg::OP_REPLY: check_reply(it, r);
            default: ;
        endcase
        r.reply_total = 16'(reply_cnt);
        return r;
    endfunction

    always @(posedge aclk) begin
        cbte_pkg::out_t want;
        if (!aresetn) begin
            bus_req <= 1'b0;
            bus_rep <= 1'b0;
            capacity <= 16'd4096;
            eng_phase = cbte_pkg::PH_IDLE;
            load_ptr = 0;
            remaining = 0;
            total_len = 0;
            sent_id = '0;
            reply_cnt = 0;
            pending_results.delete();
            errors <= 0;
            checked <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    cbte_pkg::CFG_BUS_REQ: bus_req <= cfg_wdata[0];
                    cbte_pkg::CFG_BUS_REP: bus_rep <= cfg_wdata[0];
                    cbte_pkg::CFG_CAPACITY: capacity <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(engine_step(s_data));
            end
            if (m_valid && m_ready) begin
                checked <= checked + 1;
                if (pending_results.size() == 0) begin
                    if (errors < 10) begin
                        $display("%0t: result transfer with no prediction waiting", $realtime);
                    end
                    errors <= errors + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (m_data !== want) begin
                        if (errors < 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected sv=%0b id=%h sl=%0d sd=%h dl=%0d dd=%h done=%0b st=%0d lc=%0d tot=%0d",
                                     want.send_valid, want.send_id, want.send_len,
                                     want.send_data, want.deliver_len,
                                     want.deliver_data, want.done_res, want.status,
                                     want.link_code, want.reply_total);
                            $display("  actual   sv=%0b id=%h sl=%0d sd=%h dl=%0d dd=%h done=%0b st=%0d lc=%0d tot=%0d",
                                     m_data.send_valid, m_data.send_id, m_data.send_len,
                                     m_data.send_data, m_data.deliver_len,
                                     m_data.deliver_data, m_data.done_res, m_data.status,
                                     m_data.link_code, m_data.reply_total);
                        end
                        errors <= errors + 1;
                    end
                end
            end
        end
        pending <= pending_results.size();
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block transfer engine testbench
// Preloads the start of the request buffer, runs directed corner transfers and
// then random request/reply conversations under four register settings, with
// random stalls on both channels. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int PRELOAD = 64;

    logic           aclk;
    logic           aresetn;
    logic           cfg_we;
    logic [1:0]     cfg_index;
    logic [15:0]    cfg_wdata;
    logic           s_valid;
    logic           s_ready;
    cbte_pkg::in_t  s_data;
    logic           m_valid;
    logic           m_ready;
    cbte_pkg::out_t m_data;

    int          errors;
    int          pending;
    int          checked;
    int          items_sent;
    int          transfers_started;
    bit          idle_en;
    int          stall_left;

    can_block_transfer_engine_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    cbte_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic cbte_pkg::in_t rnd_item();
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return raw[$bits(cbte_pkg::in_t)-1:0];
    endfunction

    function automatic cbte_pkg::in_t reply_frame(input logic [30:0] flags, input int len);
        cbte_pkg::in_t x;
        x = rnd_item();
        x.operation = cbte_pkg::OP_REPLY;
        x.frame_id = (31'($urandom) & 31'h07FFFFFF) | flags;
        x.frame_len = 4'(len);
        x.link_error = 3'd0;
        return x;
    endfunction

    task automatic push(input cbte_pkg::in_t x);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic push_noise();
        cbte_pkg::in_t x;
        x = rnd_item();
        case ($urandom_range(0, 5))
            0: begin
                x.operation = cbte_pkg::OP_REPLY;
                if (x.link_error == 3'd0) begin
                    x.link_error = 3'd1;
                end
            end
            1, 2: begin
                x.operation = cbte_pkg::OP_REPLY;
                x.link_error = 3'd0;
                x.frame_len = 4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0);
            end
            3: x.operation = cbte_pkg::OP_LOAD;
            4: x.operation = OP_NOP;
            default: return;
        endcase
        push(x);
    endtask

    task automatic run_transfer(input bit noisy);
        cbte_pkg::in_t x;
        int            cnt, hlen, take, rem, nxt, step, noise_at, nbytes, flen;
        bit            first;
        logic [30:0]   wflag;
        repeat ($urandom_range(0, 12)) begin
            x = rnd_item();
            x.operation = cbte_pkg::OP_LOAD;
            push(x);
        end
        x = rnd_item();
        x.operation = cbte_pkg::OP_START;
        case ($urandom_range(0, 9))
            0: x.data_type[20:16] = 5'($urandom_range(1, 30));
            1, 2, 3, 4, 5: x.data_type[20:16] = 5'h1F;
            default: x.data_type[20:16] = 5'h00;
        endcase
        cnt = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 40);
        x.data_count = 13'(cnt);
        push(x);
        transfers_started++;
        if (x.data_type[20:16] != 5'h1F && x.data_type[20:16] != 5'h00) begin
            return;
        end
        hlen = (x.data_type[20:16] == 5'h1F) ? 3 : 1;
        if (cnt > cbte_pkg::REQUEST_DEPTH) begin
            cnt = cbte_pkg::REQUEST_DEPTH;
        end
        take = cnt < 8 - hlen ? cnt : 8 - hlen;
        rem = cnt - take;
        nxt = (rem + 7) / 8;
        wflag = x.block_type[0] ? cbte_pkg::ID_WRITE : 31'd0;
        noise_at = -1;
        if (nxt > 16) begin
            noise_at = $urandom_range(0, 4);
        end else if (noisy) begin
            noise_at = $urandom_range(0, nxt + 2);
        end
        step = 0;
        for (int i = 0; i < nxt; i++) begin
            if (step == noise_at) begin
                push_noise();
                return;
            end
            push(reply_frame(cbte_pkg::ID_REPLY | wflag, 0));
            step++;
        end
        if (step == noise_at) begin
            push_noise();
            return;
        end
        if (x.block_type[0]) begin
            push(reply_frame(cbte_pkg::ID_REPLY | cbte_pkg::ID_WRITE |
                             cbte_pkg::ID_FIRST | cbte_pkg::ID_LAST, 0));
            return;
        end
        nbytes = $urandom_range(0, 30);
        if (nbytes == 0) begin
            push(reply_frame(cbte_pkg::ID_REPLY | cbte_pkg::ID_FIRST | cbte_pkg::ID_LAST, 0));
            return;
        end
        first = 1'b1;
        while (nbytes > 0) begin
            flen = $urandom_range(1, 8);
            if (flen > nbytes) begin
                flen = nbytes;
            end
            nbytes -= flen;
            push(reply_frame(cbte_pkg::ID_REPLY | (first ? cbte_pkg::ID_FIRST : 31'd0) |
                             (nbytes == 0 ? cbte_pkg::ID_LAST : 31'd0),
                             (flen == 8 && $urandom_range(0, 1)) ? $urandom_range(9, 15) : flen));
            first = 1'b0;
            step++;
            if (step == noise_at) begin
                push_noise();
                return;
            end
        end
    endtask

    task automatic write_settings(input logic req, input logic rep, input logic [15:0] cap);
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= cbte_pkg::CFG_BUS_REQ;
        cfg_wdata <= {15'd0, req};
        @(negedge aclk);
        cfg_index <= cbte_pkg::CFG_BUS_REP;
        cfg_wdata <= {15'd0, rep};
        @(negedge aclk);
        cfg_index <= cbte_pkg::CFG_CAPACITY;
        cfg_wdata <= cap;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        cbte_pkg::in_t x;
        int            target;
        logic          set_req [4] = '{1'b1, 1'b0, 1'b1, 1'b0};
        logic          set_rep [4] = '{1'b1, 1'b1, 1'b0, 1'b0};
        logic [15:0]   set_cap [4] = '{16'd65535, 16'd0, 16'd20, 16'd4096};
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b1;
        stall_left = 0;
        idle_en = 1'b1;
        items_sent = 0;
        transfers_started = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Load the low part of the request buffer; no later transfer gathers
        // bytes beyond it before a start rewinds the load pointer.
        repeat (PRELOAD) begin
            x = rnd_item();
            x.operation = cbte_pkg::OP_LOAD;
            push(x);
        end
        x = rnd_item();
        x.operation = OP_NOP;
        push(x);
        push(reply_frame(cbte_pkg::ID_REPLY | cbte_pkg::ID_FIRST, 3));

        x = rnd_item();
        x.operation = cbte_pkg::OP_START;
        x.block_type = 2'd3;
        x.node_address = 9'h1FF;
        x.source_node = 8'hFF;
        x.data_type = 21'h1FFFFF;
        x.data_count = 13'h1FFF;
        push(x);
        x = reply_frame(cbte_pkg::ID_REPLY | cbte_pkg::ID_WRITE, 0);
        x.link_error = 3'd7;
        push(x);

        x = rnd_item();
        x.operation = cbte_pkg::OP_START;
        x.block_type = 2'd0;
        x.node_address = 9'h000;
        x.source_node = 8'h00;
        x.data_type = 21'h000000;
        x.data_count = 13'd0;
        push(x);
        x = reply_frame(cbte_pkg::ID_REPLY | cbte_pkg::ID_FIRST, 15);
        x.frame_data = '1;
        push(x);
        x = reply_frame(cbte_pkg::ID_REPLY | cbte_pkg::ID_LAST, 4);
        x.frame_data = '1;
        push(x);

        x = rnd_item();
        x.operation = cbte_pkg::OP_START;
        x.data_type = 21'h0A0000;
        push(x);

        x = rnd_item();
        x.operation = cbte_pkg::OP_START;
        x.block_type = 2'd1;
        x.data_type = 21'h00001F;
        x.data_count = 13'd20;
        push(x);
        x.block_type = 2'd2;
        x.data_type = 21'h1F0000;
        x.data_count = 13'd5;
        push(x);
        push(reply_frame(31'd0, 0));
        transfers_started += 5;

        for (int p = 0; p < 4; p++) begin
            s_valid <= 1'b0;
            write_settings(set_req[p], set_rep[p], set_cap[p]);
            target = items_sent + 195;
            while (items_sent < target) begin
                idle_en = (p < 3) && ($urandom_range(0, 3) != 0);
                run_transfer($urandom_range(0, 3) == 0);
            end
        end
        s_valid <= 1'b0;
        idle_en = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        $display("Covered %0d input transfers in %0d started transfers, %0d results checked,",
                 items_sent, transfers_started, checked);
        $display("under four register settings including both capacity extremes.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
